/* hdl/slir_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted list insert/remove block.
// No dependencies.
package slir_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic                      ins_en;
    logic                      rem_en;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

/* hdl/slir_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted table: holds an entry and compares it with the item.
// Depends on slir_pkg.
module slir_cell (
  input  logic                               clk,
  input  slir_pkg::cell_cmd_t                cmd,
  input  logic                               occupied,
  input  logic                               lt_left,
  input  logic signed [slir_pkg::VALUE_W-1:0] entry_left,
  input  logic signed [slir_pkg::VALUE_W-1:0] entry_right,
  output logic signed [slir_pkg::VALUE_W-1:0] entry,
  output logic                               lt,
  output logic                               match_here
);
  import slir_pkg::*;

  logic signed [VALUE_W-1:0] entry_next;
  logic                      eq;

  // Occupied entries smaller than the item form a prefix of the row
  assign lt         = occupied && (entry < cmd.value);
  assign eq         = occupied && (entry == cmd.value);
  // This cell holds a value equal to the item and is the first not smaller than it
  assign match_here = eq && !lt && lt_left;

  always_comb begin
    entry_next = entry;
    if (cmd.ins_en) begin
      if (!lt_left) begin
        entry_next = entry_left;
      end else if (!lt) begin
        entry_next = cmd.value;
      end
    end else if (cmd.rem_en && !lt) begin
      entry_next = entry_right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* hdl/sorted_list_insert_remove.sv */
`timescale 1ns / 1ps
// Sorted table of signed values with insert and remove, top level.
// Depends on slir_pkg and slir_cell.
//
// Input channel: in_valid/in_stall with action (0 insert, 1 remove) and
// value. Output channel: out_valid/out_stall with status and entry_count.
// Every input item gives exactly one result item.
// The table is a row of DEPTH cells; all cells compare against the item in
// the same cycle and each keeps its entry or takes the item, its left or its
// right neighbour's entry, so the whole row updates together for each item.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver does not stall.
// An insert into a full table leaves it unchanged and reports full; a remove
// of an absent value reports not found.
// Reset empties the table (count to zero) and drops any waiting result.
// While the receiver stalls, the held result stays put and in_stall is
// raised, so no new item enters until the result is taken.
module sorted_list_insert_remove (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic signed [slir_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [slir_pkg::OUT_CNT_W-1:0]     entry_count
);
  import slir_pkg::*;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      full;
  logic                      found;
  status_t                   status_next;
  cell_cmd_t                 cmd;
  logic signed [VALUE_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]          lt_vec;
  logic [DEPTH-1:0]          match_vec;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(DEPTH));
  assign found    = |match_vec;

  assign cmd.value  = value;
  assign cmd.ins_en = accept && (action == ACT_INSERT) && !full;
  assign cmd.rem_en = accept && (action == ACT_REMOVE) && found;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                      lt_l;
      logic signed [VALUE_W-1:0] left_e;
      logic signed [VALUE_W-1:0] right_e;
      if (i == 0) begin : g_first
        assign lt_l   = 1'b1;
        assign left_e = entries[i];
      end else begin : g_mid
        assign lt_l   = lt_vec[i-1];
        assign left_e = entries[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_e = entries[i];
      end else begin : g_notlast
        assign right_e = entries[i+1];
      end
      slir_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (CNT_W'(i) < count),
        .lt_left     (lt_l),
        .entry_left  (left_e),
        .entry_right (right_e),
        .entry       (entries[i]),
        .lt          (lt_vec[i]),
        .match_here  (match_vec[i])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = ST_MISSING;
    if (action == ACT_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + CNT_W'(1);
      end
    end else if (found) begin
      status_next = ST_REMOVED;
      count_next  = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when an item is accepted
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      entry_count <= OUT_CNT_W'(count_next);
    end
  end

endmodule
